// File: hdl/supply_short_diag_sequencer_top_macros.svh
// Assertion macros shared by the supply short diagnosis sequencer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SUPPLY_SHORT_DIAG_SEQUENCER_TOP_MACROS_SVH
`define SUPPLY_SHORT_DIAG_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// expr holds on every clock outside reset
`define SSDIAG_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// ante in this cycle implies cons in the same cycle
`define SSDIAG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// ante in this cycle implies cons in the next cycle
`define SSDIAG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSDIAG_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define SSDIAG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSDIAG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hdl/ssdiag_pkg.sv
// Shared types and constants for the supply short diagnosis sequencer.
// No dependencies.
`timescale 1ns / 1ps

package ssdiag_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_W     = 12;
  localparam int CNT_W       = 16;
  localparam int TICK_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TICK_W-1:0]  CHECK_INTERVAL = 4'd1;
  localparam logic [TICK_W-1:0]  TICK_MAX       = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX        = '1;
  localparam logic [LEVEL_W-1:0] SAMPLE_MASK    = LEVEL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GND_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GND_COUNT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CHECKS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_TICKS    = 3'd7;

  typedef enum logic [1:0] {
    DRIVE_OFF  = 2'd0,
    DRIVE_HALF = 2'd1,
    DRIVE_FULL = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    PHASE_BATTERY = 2'd0,
    PHASE_SOFT    = 2'd1,
    PHASE_GROUND  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] diag_low;
    logic [LEVEL_W-1:0] diag_high;
    logic [LEVEL_W-1:0] batt_level;
    logic [CNT_W-1:0]   batt_count;
    logic [LEVEL_W-1:0] gnd_level;
    logic [CNT_W-1:0]   gnd_count;
    logic [CNT_W-1:0]   window_checks;
    logic [CNT_W-1:0]   soft_ticks;
  } cfg_t;

  typedef struct packed {
    drive_t drive;
    logic   heater;
    logic   power;
    logic   batt_pend;
    logic   batt_fault;
    logic   gnd_pend;
    logic   gnd_fault;
    phase_t phase;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v != CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// File: hdl/ssdiag_cfg.sv
// Configuration register file: eight write-only registers with reset values.
// Depends on ssdiag_pkg.
`timescale 1ns / 1ps

module ssdiag_cfg
  import ssdiag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t               regs;
  logic [LEVEL_W-1:0] lvl;

  // level registers keep only the sample bits
  assign lvl = wr_data[LEVEL_W-1:0] & SAMPLE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.diag_low      <= LEVEL_W'(20);
      regs.diag_high     <= LEVEL_W'(814);
      regs.batt_level    <= LEVEL_W'(168);
      regs.batt_count    <= CNT_W'(20);
      regs.gnd_level     <= LEVEL_W'(99);
      regs.gnd_count     <= CNT_W'(80);
      regs.window_checks <= CNT_W'(40);
      regs.soft_ticks    <= CNT_W'(10);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DIAG_LOW:      regs.diag_low      <= lvl;
        REG_DIAG_HIGH:     regs.diag_high     <= lvl;
        REG_BATT_LEVEL:    regs.batt_level    <= lvl;
        REG_BATT_COUNT:    regs.batt_count    <= wr_data;
        REG_GND_LEVEL:     regs.gnd_level     <= lvl;
        REG_GND_COUNT:     regs.gnd_count     <= wr_data;
        REG_WINDOW_CHECKS: regs.window_checks <= wr_data;
        REG_SOFT_TICKS:    regs.soft_ticks    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hdl/ssdiag_core.sv
// Sequencer state and the per-tick update: battery window, soft start,
// ground check. Depends on ssdiag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "supply_short_diag_sequencer_top_macros.svh"

module ssdiag_core
  import ssdiag_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  cfg_t               cfg,
  input  logic [LEVEL_W-1:0] ign_in,
  input  logic [LEVEL_W-1:0] sup_in,
  output res_t               res_next
);

  logic [TICK_W-1:0] tick, tick_next;
  logic              batt_act, batt_act_next;
  logic [CNT_W-1:0]  batt_done, batt_done_next;
  logic [CNT_W-1:0]  batt_hits, batt_hits_next;
  logic              soft_act, soft_act_next;
  logic [CNT_W-1:0]  soft_cnt, soft_cnt_next;
  logic              gnd_act, gnd_act_next;
  logic [CNT_W-1:0]  gnd_hits, gnd_hits_next;
  drive_t            drive, drive_next;
  logic              heater, heater_next;
  logic              power, power_next;
  logic              bpend, bpend_next;
  logic              bfault, bfault_next;
  logic              gpend, gpend_next;
  logic              gfault, gfault_next;

  logic [LEVEL_W-1:0] ign, sup;
  logic               in_win, due, due_gnd;

  assign ign    = ign_in & SAMPLE_MASK;
  assign sup    = sup_in & SAMPLE_MASK;
  assign in_win = (ign >= cfg.diag_low) && (ign <= cfg.diag_high);
  assign due    = tick >= CHECK_INTERVAL;

  always_comb begin
    tick_next      = (tick != TICK_MAX) ? tick + TICK_W'(1) : tick;
    batt_act_next  = batt_act;
    batt_done_next = batt_done;
    batt_hits_next = batt_hits;
    soft_act_next  = soft_act;
    soft_cnt_next  = soft_cnt;
    gnd_act_next   = gnd_act;
    gnd_hits_next  = gnd_hits;
    drive_next     = drive;
    heater_next    = heater;
    power_next     = power;
    bpend_next     = bpend;
    bfault_next    = bfault;
    gpend_next     = gpend;
    gfault_next    = gfault;
    due_gnd        = due;

    if (batt_act && due) begin
      if (in_win && (sup >= cfg.batt_level)) begin
        batt_hits_next = sat_inc(batt_hits);
        if (batt_hits_next == CNT_W'(1)) bpend_next = 1'b1;
        if (batt_hits_next == cfg.batt_count) bfault_next = 1'b1;
      end else begin
        batt_hits_next = '0;
        bpend_next     = 1'b0;
      end
      batt_done_next = sat_inc(batt_done);
      if (batt_done_next == cfg.window_checks) begin
        batt_act_next = 1'b0;
        soft_act_next = 1'b1;
      end
      tick_next = '0;
      due_gnd   = 1'b0;
    end

    // soft start runs on the handover tick too
    if (soft_act_next) begin
      soft_cnt_next = sat_inc(soft_cnt);
      if (soft_cnt_next == CNT_W'(1)) drive_next = DRIVE_HALF;
      if (soft_cnt_next > cfg.soft_ticks) begin
        drive_next    = DRIVE_FULL;
        soft_act_next = 1'b0;
        heater_next   = 1'b1;
        power_next    = 1'b1;
        gnd_act_next  = 1'b1;
      end
    end

    if (gnd_act_next && due_gnd) begin
      if (in_win && (sup <= cfg.gnd_level)) begin
        gnd_hits_next = sat_inc(gnd_hits);
        if (gnd_hits_next == CNT_W'(1)) gpend_next = 1'b1;
        if (gnd_hits_next == cfg.gnd_count) gfault_next = 1'b1;
      end else begin
        gnd_hits_next = '0;
        gpend_next    = 1'b0;
      end
      tick_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      batt_act  <= 1'b1;
      batt_done <= '0;
      batt_hits <= '0;
      soft_act  <= 1'b0;
      soft_cnt  <= '0;
      gnd_act   <= 1'b0;
      gnd_hits  <= '0;
      drive     <= DRIVE_OFF;
      heater    <= 1'b0;
      power     <= 1'b0;
      bpend     <= 1'b0;
      bfault    <= 1'b0;
      gpend     <= 1'b0;
      gfault    <= 1'b0;
    end else if (step) begin
      tick      <= tick_next;
      batt_act  <= batt_act_next;
      batt_done <= batt_done_next;
      batt_hits <= batt_hits_next;
      soft_act  <= soft_act_next;
      soft_cnt  <= soft_cnt_next;
      gnd_act   <= gnd_act_next;
      gnd_hits  <= gnd_hits_next;
      drive     <= drive_next;
      heater    <= heater_next;
      power     <= power_next;
      bpend     <= bpend_next;
      bfault    <= bfault_next;
      gpend     <= gpend_next;
      gfault    <= gfault_next;
    end
  end

  always_comb begin
    res_next.drive      = drive_next;
    res_next.heater     = heater_next;
    res_next.power      = power_next;
    res_next.batt_pend  = bpend_next;
    res_next.batt_fault = bfault_next;
    res_next.gnd_pend   = gpend_next;
    res_next.gnd_fault  = gfault_next;
    if (batt_act_next)     res_next.phase = PHASE_BATTERY;
    else if (soft_act_next) res_next.phase = PHASE_SOFT;
    else                    res_next.phase = PHASE_GROUND;
  end

  // exactly one phase is live at any time
  `SSDIAG_ASSERT_ALWAYS(a_one_phase, clk, rst, $onehot({batt_act, soft_act, gnd_act}))
  // latched faults never clear outside reset
  `SSDIAG_ASSERT_NEXT(a_bfault_latch, clk, rst, bfault, bfault)
  `SSDIAG_ASSERT_NEXT(a_gfault_latch, clk, rst, gfault, gfault)
  // ground phase only after full drive and both enables
  `SSDIAG_ASSERT_IMP(a_gnd_powered, clk, rst, gnd_act,
                     (drive == DRIVE_FULL) && heater && power)
  // nothing is driven during the battery window
  `SSDIAG_ASSERT_IMP(a_batt_quiet, clk, rst, batt_act,
                     (drive == DRIVE_OFF) && !heater && !gpend && !gfault)

endmodule

// File: hdl/supply_short_diag_sequencer_top.sv
// A request accepted into the input register has its result registered once the result slot is
// free or being drained (out_valid high after it). Throughput: one request per cycle unless the
// result stalls; the input register takes one more while the result stalls.
// The whole tick update sits between the input register and the result register.
// Reset (rst, synchronous): config registers return to defaults, sequencer to battery window.
// Config writes are always ready and take effect at once.
// Depends on ssdiag_pkg, ssdiag_cfg and ssdiag_core.
`timescale 1ns / 1ps

module supply_short_diag_sequencer_top
  import ssdiag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEVEL_W-1:0]    ignition_level,
  input  logic [LEVEL_W-1:0]    supply_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            drive_mode,
  output logic                  heater_enable,
  output logic                  power_enable,
  output logic                  battery_short_pending,
  output logic                  battery_short_fault,
  output logic                  ground_short_pending,
  output logic                  ground_short_fault,
  output logic [1:0]            phase
);

  cfg_t               cfg;
  res_t               res_next, res;
  logic               in_q_valid;
  logic [LEVEL_W-1:0] ign_q, sup_q;
  logic               advance;

  assign cfg_ready = 1'b1;

  ssdiag_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input stage moves on when the result slot is free or being drained
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ign_q <= ignition_level;
      sup_q <= supply_level;
    end
  end

  ssdiag_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cfg      (cfg),
    .ign_in   (ign_q),
    .sup_in   (sup_q),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign drive_mode            = res.drive;
  assign heater_enable         = res.heater;
  assign power_enable          = res.power;
  assign battery_short_pending = res.batt_pend;
  assign battery_short_fault   = res.batt_fault;
  assign ground_short_pending  = res.gnd_pend;
  assign ground_short_fault    = res.gnd_fault;
  assign phase                 = res.phase;

endmodule
